FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle check, sampled on i_clk, off during reset
`define FLRB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("flrb check failed");

// next-cycle implication
`define FLRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("flrb sequence check failed");

`endif

FILE: hw/rtl/flrb_pkg.sv
// ---------------------------------------------------------------------------
// flrb_pkg
// shared types and constants of the line reuse buffer
// ---------------------------------------------------------------------------
package flrb_pkg;

    localparam int LINES     = 16;
    localparam int NPART     = 8;
    localparam int WORDS     = 8;
    localparam int ADDR_W    = 42;
    localparam int DATA_W    = 64;
    localparam int CORE_W    = 6;
    localparam int CAP_W     = 5;
    localparam int SLOT_W    = $clog2(LINES);
    localparam int PART_W    = $clog2(NPART);
    localparam int WORD_W    = $clog2(WORDS);
    localparam int FILL_W    = $clog2(LINES + 1);
    localparam int MAXL_RST  = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_READ   = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_DISABLED = 2'd2,
        ST_BADCORE  = 2'd3
    } t_status;

    typedef enum logic {
        CFG_MAX_LINES = 1'b0,
        CFG_PER_CORE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_EMIT,
        BS_TAGRD,
        BS_TAGCMP,
        BS_EVICT,
        BS_WRTAG,
        BS_COPY,
        BS_DRD,
        BS_DOUT
    } t_bstate;

    typedef struct packed {
        logic               ovr;
        t_status            status;
        t_op                op;
        logic [PART_W-1:0]  part;
        logic [ADDR_W-1:0]  addr;
        logic [WORD_W-1:0]  widx;
        logic [DATA_W-1:0]  data;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [WORD_W-1:0]  widx;
        logic [DATA_W-1:0]  data;
        logic               last;
    } t_res;

    typedef struct packed {
        logic [FILL_W-1:0]  cap;
    } t_cfg;

    typedef struct packed {
        logic               busy;
    } t_bstat;

endpackage

FILE: hw/rtl/flrb_front.sv
// ---------------------------------------------------------------------------
// flrb_front
// config registers, request classification and a two-deep command queue
// ---------------------------------------------------------------------------
module flrb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [flrb_pkg::CAP_W-1:0]    i_cfg_data,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [1:0]                    i_op,
    input  logic [flrb_pkg::CORE_W-1:0]   i_core_id,
    input  logic [flrb_pkg::ADDR_W-1:0]   i_line_addr,
    input  logic [flrb_pkg::WORD_W-1:0]   i_word_index,
    input  logic [flrb_pkg::DATA_W-1:0]   i_data_word,
    output logic                          o_cmd_valid,
    output flrb_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop,
    output flrb_pkg::t_cfg                o_cfg
);
    import flrb_pkg::*;

    logic [CAP_W-1:0] r_max_lines;
    logic             r_per_core;
    t_cmd             r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    t_cmd             w_cmd;
    logic             w_in, w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lines <= CAP_W'(MAXL_RST);
            r_per_core  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_LINES: r_max_lines <= i_cfg_data;
                CFG_PER_CORE:  r_per_core  <= i_cfg_data[0];
                default:       r_per_core  <= r_per_core;
            endcase
        end
    end

    always_comb begin
        o_cfg.cap = (r_max_lines > CAP_W'(LINES)) ? FILL_W'(LINES) : FILL_W'(r_max_lines);
    end

    // classify: disabled and bad core ids short-circuit the back end
    always_comb begin
        w_cmd.ovr    = 1'b0;
        w_cmd.status = ST_HIT;
        w_cmd.op     = t_op'(i_op);
        w_cmd.part   = '0;
        w_cmd.addr   = i_line_addr;
        w_cmd.widx   = i_word_index;
        w_cmd.data   = i_data_word;
        if (r_max_lines == '0) begin
            w_cmd.ovr    = 1'b1;
            w_cmd.status = ST_DISABLED;
        end else if (r_per_core) begin
            if ({1'b0, i_core_id} >= (CORE_W+1)'(NPART)) begin
                w_cmd.ovr    = 1'b1;
                w_cmd.status = ST_BADCORE;
            end else begin
                w_cmd.part = i_core_id[PART_W-1:0];
            end
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_in        = i_push && !o_full;
    assign w_out       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in)  r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) r_q[r_wp] <= w_cmd;
    end

endmodule

FILE: hw/rtl/flrb_back.sv
// ---------------------------------------------------------------------------
// flrb_back
// executes commands: slot search, fifo eviction, line commit and read-out
// ---------------------------------------------------------------------------
module flrb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  flrb_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    input  flrb_pkg::t_cfg  i_cfg,
    output logic            o_res_push,
    output flrb_pkg::t_res  o_res,
    input  logic            i_res_full,
    output flrb_pkg::t_bstat o_stat
);
    import flrb_pkg::*;

    localparam int ENT   = NPART * LINES;
    localparam int ENT_W = PART_W + SLOT_W;

    t_bstate             r_state, n_state;
    t_cmd                r_cmd;
    t_res                r_res;
    logic [SLOT_W-1:0]   r_slot;
    logic [WORD_W-1:0]   r_word;
    logic                r_commit;
    logic [ENT-1:0]      r_valid;
    logic [SLOT_W-1:0]   r_oldest [NPART];
    logic [FILL_W-1:0]   r_fill   [NPART];
    logic [DATA_W-1:0]   r_stage  [WORDS];
    logic [ADDR_W-1:0]   r_tag_q;
    logic [DATA_W-1:0]   r_line_q;
    logic [ADDR_W-1:0]   mem_tag  [ENT];
    logic [DATA_W-1:0]   mem_line [ENT*WORDS];

    logic [ENT_W-1:0]    w_ent;
    logic [ENT_W-1:0]    w_old_ent;
    logic                w_match;
    logic                w_evict_more;
    logic                w_slot_last;
    logic                w_word_last;

    assign w_ent        = {r_cmd.part, r_slot};
    assign w_old_ent    = {r_cmd.part, r_oldest[r_cmd.part]};
    assign w_match      = r_valid[w_ent] && (r_tag_q == r_cmd.addr);
    assign w_evict_more = (r_fill[r_cmd.part] >= i_cfg.cap) && (r_fill[r_cmd.part] != '0);
    assign w_slot_last  = (r_slot == SLOT_W'(LINES - 1));
    assign w_word_last  = (r_word == WORD_W'(WORDS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.ovr || i_cmd.op == OP_ADD) n_state = BS_EMIT;
                    else                                 n_state = BS_TAGRD;
                end
            end
            BS_EMIT: begin
                if (!i_res_full) n_state = r_commit ? BS_TAGRD : BS_IDLE;
            end
            BS_TAGRD: n_state = BS_TAGCMP;
            BS_TAGCMP: begin
                if (w_match) begin
                    if (r_commit)                 n_state = BS_WRTAG;
                    else if (r_cmd.op == OP_READ) n_state = BS_DRD;
                    else                          n_state = BS_EMIT;
                end else if (w_slot_last) begin
                    n_state = r_commit ? BS_EVICT : BS_EMIT;
                end else begin
                    n_state = BS_TAGRD;
                end
            end
            BS_EVICT: if (!w_evict_more) n_state = BS_WRTAG;
            BS_WRTAG: n_state = BS_COPY;
            BS_COPY:  if (w_word_last) n_state = BS_IDLE;
            BS_DRD:   n_state = BS_DOUT;
            BS_DOUT: begin
                if (!i_res_full) n_state = w_word_last ? BS_IDLE : BS_DRD;
            end
            default:  n_state = BS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = r_res;
        o_stat.busy = (r_state != BS_IDLE);
        case (r_state)
            BS_IDLE: o_cmd_pop  = i_cmd_valid;
            BS_EMIT: o_res_push = !i_res_full;
            BS_DOUT: begin
                o_res_push  = !i_res_full;
                o_res.status = ST_HIT;
                o_res.widx   = r_word;
                o_res.data   = r_line_q;
                o_res.last   = w_word_last;
            end
            default: o_res_push = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_commit <= 1'b0;
            r_valid  <= '0;
            for (int p = 0; p < NPART; p++) begin
                r_oldest[p] <= '0;
                r_fill[p]   <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                BS_IDLE: begin
                    if (i_cmd_valid) begin
                        r_commit <= !i_cmd.ovr && (i_cmd.op == OP_ADD)
                                    && (i_cmd.widx == WORD_W'(WORDS - 1));
                    end
                end
                BS_EVICT: begin
                    if (w_evict_more) begin
                        r_valid[w_old_ent]        <= 1'b0;
                        r_oldest[r_cmd.part]      <= r_oldest[r_cmd.part] + 1'b1;
                        r_fill[r_cmd.part]        <= r_fill[r_cmd.part] - 1'b1;
                    end else begin
                        r_fill[r_cmd.part]        <= r_fill[r_cmd.part] + 1'b1;
                    end
                end
                BS_WRTAG: r_valid[w_ent] <= 1'b1;
                default:  r_commit <= r_commit;
            endcase
        end
    end

    // payload, staging and memories
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd  <= i_cmd;
                    r_slot <= '0;
                    r_word <= '0;
                    if (i_cmd.ovr) begin
                        r_res <= '{status: i_cmd.status, widx: '0, data: '0, last: 1'b1};
                    end else begin
                        r_res <= '{status: ST_HIT, widx: i_cmd.widx, data: '0, last: 1'b1};
                    end
                    if (!i_cmd.ovr && i_cmd.op == OP_ADD) r_stage[i_cmd.widx] <= i_cmd.data;
                end
            end
            BS_TAGRD: r_tag_q <= mem_tag[w_ent];
            BS_TAGCMP: begin
                if (!w_match && !w_slot_last) r_slot <= r_slot + 1'b1;
                r_res <= '{status: (w_match ? ST_HIT : ST_MISS), widx: '0, data: '0,
                           last: 1'b1};
            end
            BS_EVICT: begin
                // new line goes right after the youngest one
                if (!w_evict_more)
                    r_slot <= r_oldest[r_cmd.part] + r_fill[r_cmd.part][SLOT_W-1:0];
            end
            BS_WRTAG: begin
                mem_tag[w_ent] <= r_cmd.addr;
                r_word         <= '0;
            end
            BS_COPY: begin
                mem_line[{w_ent, r_word}] <= r_stage[r_word];
                r_word <= r_word + 1'b1;
            end
            BS_DRD:  r_line_q <= mem_line[{w_ent, r_word}];
            BS_DOUT: if (!i_res_full) r_word <= r_word + 1'b1;
            default: r_word <= r_word;
        endcase
    end

endmodule

FILE: hw/rtl/flrb_resq.sv
// ---------------------------------------------------------------------------
// flrb_resq
// two-deep result queue between the back end and the consumer
// ---------------------------------------------------------------------------
module flrb_resq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  flrb_pkg::t_res  i_res,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output flrb_pkg::t_res  o_res
);
    import flrb_pkg::*;

    t_res       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_in, w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_q[r_rp];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in)  r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) r_q[r_wp] <= i_res;
    end

endmodule

FILE: hw/rtl/fifo_line_reuse_buffer_unit.sv
// ---------------------------------------------------------------------------
// fifo_line_reuse_buffer_unit
// fully associative line buffer with per-partition fifo replacement
// ---------------------------------------------------------------------------
// requests enter through i_push/o_full, one word per request; results leave
// through o_empty/i_pop, oldest first, o_last marking the final word of each.
// config (i_cfg_we, i_cfg_idx, i_cfg_data) is to be written only while idle
// by the user; the block itself does not enforce it. a two-deep command
// queue decouples the front end from the back end and a two-deep result
// queue sits on the output, so the input keeps accepting while a result
// waits to be popped. the back end handles one request at a time; its tag
// search reads one tag at a time from the tag ram, a read state then a
// compare state per slot, up to 16 slots, stopping at the first match:
//   disabled / bad core, add with no commit: result emitted directly
//   lookup: search, then a hit or miss result
//   read hit: search, then the 8 words read from the line ram one by one
//   add of last word: result, search, tag write, 8 line-ram writes, with
//   evictions of the oldest lines first when the address is new
// reset clears valid bits, fill counts and oldest pointers at once; no
// clearing pass. a stalled consumer fills the result queue, then the back
// end holds, then the command queue fills and o_full rises.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_line_reuse_buffer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [flrb_pkg::CAP_W-1:0]    i_cfg_data,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [1:0]                    i_op,
    input  logic [flrb_pkg::CORE_W-1:0]   i_core_id,
    input  logic [flrb_pkg::ADDR_W-1:0]   i_line_addr,
    input  logic [flrb_pkg::WORD_W-1:0]   i_word_index,
    input  logic [flrb_pkg::DATA_W-1:0]   i_data_word,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [1:0]                    o_status,
    output logic [flrb_pkg::WORD_W-1:0]   o_word_index_res,
    output logic [flrb_pkg::DATA_W-1:0]   o_data_word_res,
    output logic                          o_last
);
    import flrb_pkg::*;

    logic   w_cmd_valid, w_cmd_pop, w_res_push, w_res_full;
    t_cmd   w_cmd;
    t_cfg   w_cfg;
    t_res   w_res_in, w_res_out;
    t_bstat w_bstat;

    flrb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_op         (i_op),
        .i_core_id    (i_core_id),
        .i_line_addr  (i_line_addr),
        .i_word_index (i_word_index),
        .i_data_word  (i_data_word),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_pop    (w_cmd_pop),
        .o_cfg        (w_cfg)
    );

    flrb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_cfg       (w_cfg),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .i_res_full  (w_res_full),
        .o_stat      (w_bstat)
    );

    flrb_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_res   (w_res_out)
    );

    assign o_status         = w_res_out.status;
    assign o_word_index_res = w_res_out.widx;
    assign o_data_word_res  = w_res_out.data;
    assign o_last           = w_res_out.last;

    // only a read stream produces non-final words, and they are hits
    `FLRB_ASSERT(a_mid_word_is_hit, (o_empty || o_last || o_status == ST_HIT))
    // non-final words never carry the last word index
    `FLRB_ASSERT(a_mid_word_index, (o_empty || o_last || o_word_index_res != WORD_W'(WORDS - 1)))
    // after popping a non-final word, the rest of the line is queued or coming
    `FLRB_ASSERT_NEXT(a_stream_continues, (!o_empty && i_pop && !o_last), (!o_empty || w_bstat.busy))

endmodule
